// ===== design/ksa_pkg.sv =====
// shared types, codes and constants for the knob setpoint adjuster
`default_nettype none
package ksa_pkg;

  localparam int TEMP_W  = 12;
  localparam int SPEED_W = 12;
  localparam int TIME_W  = 17;
  localparam int RATE_W  = 10;
  localparam int COUNT_W = 8;
  localparam int CMD_W   = 3;
  localparam int SEL_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int KNOBS      = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_KNOB0    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_KNOB1    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEL_TIME = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  // target codes
  localparam logic [SEL_W-1:0] TGT_NONE  = 2'd0;
  localparam logic [SEL_W-1:0] TGT_TEMP  = 2'd1;
  localparam logic [SEL_W-1:0] TGT_SPEED = 2'd2;
  localparam logic [SEL_W-1:0] TGT_TIME  = 2'd3;

  // blink codes
  localparam logic [1:0] BLINK_NONE  = 2'd0;
  localparam logic [1:0] BLINK_TEMP  = 2'd1;
  localparam logic [1:0] BLINK_SPEED = 2'd2;
  localparam logic [1:0] BLINK_TIME  = 2'd3;

  // knob activity codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_KNOB0 = 2'd1;
  localparam logic [1:0] ACT_KNOB1 = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD = 3'd4;

  // register reset values
  localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RST     = 12'd3500;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST    = 12'd1500;
  localparam logic [SPEED_W-1:0] SPEED_FLOOR_RST    = 12'd100;
  localparam logic [TIME_W-1:0]  TIME_LIMIT_RST     = 17'd86399;
  localparam logic [RATE_W-1:0]  FAST_THRESHOLD_RST = 10'd30;

  // step sizes and thresholds
  localparam logic [4:0]         TEMP_STEP_FINE   = 5'd5;
  localparam logic [4:0]         TEMP_STEP_MID    = 5'd10;
  localparam logic [4:0]         TEMP_STEP_COARSE = 5'd20;
  localparam logic [TEMP_W-1:0]  TEMP_FINE_BELOW  = 12'd1000;
  localparam logic [4:0]         SPEED_STEP_FINE   = 5'd10;
  localparam logic [4:0]         SPEED_STEP_COARSE = 5'd30;
  localparam logic [SPEED_W:0]   SPEED_START       = 13'd100;
  localparam logic [8:0]         TIME_STEP_FINE   = 9'd60;
  localparam logic [8:0]         TIME_STEP_COARSE = 9'd300;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'd255;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_limit;
    logic [SPEED_W-1:0] speed_limit;
    logic [SPEED_W-1:0] speed_floor;
    logic [TIME_W-1:0]  time_limit;
    logic [RATE_W-1:0]  fast_threshold;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0]                temp_value;
    logic [SPEED_W-1:0]               speed_value;
    logic [TIME_W-1:0]                time_value;
    logic [SEL_W-1:0]                 selected;
    logic [KNOBS-1:0][COUNT_W-1:0]    edge_count;
    logic [KNOBS-1:0][RATE_W-1:0]     knob_rate;
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             phase_b_level;
    logic             locked;
  } item_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_setpoint;
    logic [SPEED_W-1:0] speed_setpoint;
    logic [TIME_W-1:0]  time_setpoint;
    logic [SEL_W-1:0]   target;
    logic [1:0]         blink_request;
    logic [1:0]         knob_active;
  } result_t;

endpackage
`default_nettype wire

// ===== design/ksa_cfg.sv =====
// configuration register file of the knob setpoint adjuster
`default_nettype none
module ksa_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [ksa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ksa_pkg::CFG_DATA_W-1:0] cfg_data,
  output ksa_pkg::cfg_t                      cfg
);
  import ksa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_limit     <= TEMP_LIMIT_RST;
      cfg.speed_limit    <= SPEED_LIMIT_RST;
      cfg.speed_floor    <= SPEED_FLOOR_RST;
      cfg.time_limit     <= TIME_LIMIT_RST;
      cfg.fast_threshold <= FAST_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_LIMIT:     cfg.temp_limit     <= cfg_data[TEMP_W-1:0];
        REG_SPEED_LIMIT:    cfg.speed_limit    <= cfg_data[SPEED_W-1:0];
        REG_SPEED_FLOOR:    cfg.speed_floor    <= cfg_data[SPEED_W-1:0];
        REG_TIME_LIMIT:     cfg.time_limit     <= cfg_data[TIME_W-1:0];
        REG_FAST_THRESHOLD: cfg.fast_threshold <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ksa_core.sv =====
// single-pass update of setpoints, selection and knob rates for one item
`default_nettype none
module ksa_core (
  input  ksa_pkg::item_t   item,
  input  ksa_pkg::state_t  state,
  input  ksa_pkg::cfg_t    cfg,
  output ksa_pkg::state_t  state_next,
  output ksa_pkg::result_t result
);
  import ksa_pkg::*;

  logic               knob;
  logic               coarse;
  logic               down;
  logic [SEL_W-1:0]   sel_edge;
  logic [4:0]         temp_step;
  logic [TEMP_W:0]    temp_sum;
  logic [TEMP_W-1:0]  temp_new;
  logic [4:0]         speed_step;
  logic [SPEED_W:0]   speed_sum;
  logic [SPEED_W-1:0] speed_diff;
  logic [SPEED_W-1:0] speed_new;
  logic [8:0]         time_step;
  logic [TIME_W:0]    time_sum;
  logic [TIME_W-1:0]  time_new;
  logic [1:0]         blink;
  logic [1:0]         active;

  assign knob   = item.command[0];
  assign down   = item.phase_b_level;
  assign coarse = state.knob_rate[knob] >= cfg.fast_threshold;

  // selection after a knob edge; a time selection sticks
  assign sel_edge = (state.selected == TGT_TIME) ? TGT_TIME
                  : (knob ? TGT_SPEED : TGT_TEMP);

  // temperature: coarse step on a fast knob, else a finer step below the fine threshold
  always_comb begin
    if (coarse) begin
      temp_step = TEMP_STEP_COARSE;
    end else if (state.temp_value < TEMP_FINE_BELOW) begin
      temp_step = TEMP_STEP_FINE;
    end else begin
      temp_step = TEMP_STEP_MID;
    end
    temp_sum = {1'b0, state.temp_value} + (TEMP_W + 1)'(temp_step);
    if (!down) begin
      temp_new = (temp_sum > {1'b0, cfg.temp_limit}) ? cfg.temp_limit
                                                      : temp_sum[TEMP_W-1:0];
    end else if (state.temp_value < TEMP_W'(temp_step)) begin
      temp_new = '0;
    end else begin
      temp_new = state.temp_value - TEMP_W'(temp_step);
    end
  end

  // speed: raising from zero lands on the start value, low results drop to zero
  always_comb begin
    speed_step = coarse ? SPEED_STEP_COARSE : SPEED_STEP_FINE;
    speed_sum  = (state.speed_value == '0) ? SPEED_START
               : {1'b0, state.speed_value} + (SPEED_W + 1)'(speed_step);
    speed_diff = state.speed_value - SPEED_W'(speed_step);
    if (!down) begin
      speed_new = (speed_sum > {1'b0, cfg.speed_limit}) ? cfg.speed_limit
                                                         : speed_sum[SPEED_W-1:0];
    end else if (state.speed_value < SPEED_W'(speed_step)) begin
      speed_new = '0;
    end else if (speed_diff < cfg.speed_floor) begin
      speed_new = '0;
    end else begin
      speed_new = speed_diff;
    end
  end

  // time
  always_comb begin
    time_step = coarse ? TIME_STEP_COARSE : TIME_STEP_FINE;
    time_sum  = {1'b0, state.time_value} + (TIME_W + 1)'(time_step);
    if (!down) begin
      time_new = (time_sum > {1'b0, cfg.time_limit}) ? cfg.time_limit
                                                      : time_sum[TIME_W-1:0];
    end else if (state.time_value < TIME_W'(time_step)) begin
      time_new = '0;
    end else begin
      time_new = state.time_value - TIME_W'(time_step);
    end
  end

  always_comb begin
    state_next = state;
    blink      = BLINK_NONE;
    active     = ACT_NONE;
    case (item.command)
      CMD_KNOB0, CMD_KNOB1: begin
        if (!item.locked) begin
          active = knob ? ACT_KNOB1 : ACT_KNOB0;
          if (state.edge_count[knob] != COUNT_MAX) begin
            state_next.edge_count[knob] = state.edge_count[knob] + COUNT_W'(1);
          end
          state_next.selected = sel_edge;
          if (sel_edge == TGT_TIME) begin
            state_next.time_value = time_new;
            blink = BLINK_TIME;
          end else if (knob) begin
            state_next.speed_value = speed_new;
            blink = BLINK_SPEED;
          end else begin
            state_next.temp_value = temp_new;
            blink = BLINK_TEMP;
          end
        end
      end
      CMD_TICK: begin
        for (int k = 0; k < KNOBS; k++) begin
          // count times three, fits the rate width
          state_next.knob_rate[k]  = {2'b00, state.edge_count[k]}
                                   + {1'b0, state.edge_count[k], 1'b0};
          state_next.edge_count[k] = '0;
        end
      end
      CMD_SEL_TIME: state_next.selected = TGT_TIME;
      CMD_CLEAR:    state_next.selected = TGT_NONE;
      default: ;
    endcase
  end

  assign result.temp_setpoint  = state_next.temp_value;
  assign result.speed_setpoint = state_next.speed_value;
  assign result.time_setpoint  = state_next.time_value;
  assign result.target         = state_next.selected;
  assign result.blink_request  = blink;
  assign result.knob_active    = active;

endmodule
`default_nettype wire

// ===== design/knob_setpoint_adjuster_unit.sv =====
// top level of the knob setpoint adjuster: input stage, state, result register
// an item's result is valid once it has passed the input stage, then the result
//   register; one item per cycle sustained while the output does not stall
// the input stage refills while a result waits, so the input stalls only when
//   both the input stage and the result register are full and output stalls
// reset: setpoints, selection, edge counts and knob rates clear, registers
//   return to their default limits, both stages empty
`default_nettype none
module knob_setpoint_adjuster_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration writes
  input  wire logic                          cfg_write,
  input  wire logic [ksa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ksa_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [ksa_pkg::CMD_W-1:0]      command,
  input  wire logic                          phase_b_level,
  input  wire logic                          locked,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [ksa_pkg::TEMP_W-1:0]          temp_setpoint,
  output logic [ksa_pkg::SPEED_W-1:0]         speed_setpoint,
  output logic [ksa_pkg::TIME_W-1:0]          time_setpoint,
  output logic [ksa_pkg::SEL_W-1:0]           target,
  output logic [1:0]                         blink_request,
  output logic [1:0]                         knob_active
);
  import ksa_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   stage_item;
  logic    stage_valid;
  result_t result_next;
  result_t result;
  logic    advance;
  logic    item_take;

  // register file
  ksa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the staged item moves on when the result register is free or draining
  assign advance    = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && !advance;
  assign item_take  = item_valid && !item_stall;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item_take) begin
      stage_item.command       <= command;
      stage_item.phase_b_level <= phase_b_level;
      stage_item.locked        <= locked;
    end
  end

  // all the per-item work
  ksa_core u_core (
    .item       (stage_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  // state commits only when the item's result is captured
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign temp_setpoint  = result.temp_setpoint;
  assign speed_setpoint = result.speed_setpoint;
  assign time_setpoint  = result.time_setpoint;
  assign target         = result.target;
  assign blink_request  = result.blink_request;
  assign knob_active    = result.knob_active;

  // a staged item always lands in the result register when it advances
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced item did not reach the result register");

  // a setpoint blinks exactly when a knob edge was taken
  a_blink_iff_knob: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((knob_active == ACT_NONE) == (blink_request == BLINK_NONE)))
    else $error("blink request and knob activity disagree");

  // outside time selection, knob 1 always adjusts speed
  a_knob1_speed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && knob_active == ACT_KNOB1 && target != TGT_TIME)
      |-> (blink_request == BLINK_SPEED && target == TGT_SPEED))
    else $error("knob 1 edge did not adjust speed");

  // the input stalls only with a staged item held back by the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (stage_valid && result_valid && result_stall))
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire
